// ----- hdl/pep_pkg.sv -----
// Shared types, constants and helpers for the palette expander.
package pep_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_AW = $clog2(PALETTE_ENTRIES);
  localparam int MAX_SCALE = 8;
  localparam int PADDR_W = 5;

  // register indexes (paddr[4:2])
  localparam logic [2:0] REG_SCALE = 3'd0;
  localparam logic [2:0] REG_OUTPUT_MODE = 3'd1;
  localparam logic [2:0] REG_RED_FIELD = 3'd2;
  localparam logic [2:0] REG_GREEN_FIELD = 3'd3;
  localparam logic [2:0] REG_BLUE_FIELD = 3'd4;

  // item mode codes
  localparam logic MODE_PAL_WRITE = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  // output mode codes
  localparam logic OUT_PACKED = 1'b0;
  localparam logic OUT_TRUE_COLOR = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_in_line;
  } item_t;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
    logic        line_end;
  } res_t;

  typedef struct packed {
    logic [3:0]  scale;
    logic        output_mode;
    logic [31:0] red_field;
    logic [31:0] green_field;
    logic [31:0] blue_field;
    logic [4:0]  red_shift;
    logic [4:0]  green_shift;
    logic [4:0]  blue_shift;
  } cfg_t;

  // pixel handed from the lookup stage to the packer
  typedef struct packed {
    logic [7:0]  index;
    logic        eol;
    logic [31:0] word;
  } job_t;

  function automatic logic [4:0] low_bit_pos(input logic [31:0] m);
    logic [4:0] pos;
    pos = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (m[i]) pos = 5'(i);
    end
    return pos;
  endfunction

  function automatic logic [31:0] place(input logic [7:0] comp, input logic [31:0] m,
                                        input logic [4:0] sh);
    return ({24'd0, comp} << sh) & m;
  endfunction

  function automatic logic [3:0] eff_scale(input logic [3:0] s);
    logic [3:0] r;
    r = s;
    if (r == 4'd0) r = 4'd1;
    if (r > 4'(MAX_SCALE)) r = 4'(MAX_SCALE);
    return r;
  endfunction

endpackage

// ----- hdl/pep_ram.sv -----
// Generic single-port-write, registered-read RAM.
module pep_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// ----- hdl/pep_regs.sv -----
// APB configuration registers with precomputed mask shifts.
module pep_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pep_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output pep_pkg::cfg_t              cfg
);
  import pep_pkg::*;

  logic [2:0] sel;
  logic       wr;

  assign pready = 1'b1;
  assign sel = paddr[4:2];
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale <= 4'd1;
      cfg.output_mode <= OUT_PACKED;
      cfg.red_field <= 32'h00FF_0000;
      cfg.green_field <= 32'h0000_FF00;
      cfg.blue_field <= 32'h0000_00FF;
      cfg.red_shift <= 5'd16;
      cfg.green_shift <= 5'd8;
      cfg.blue_shift <= 5'd0;
    end else if (wr) begin
      case (sel)
        REG_SCALE: cfg.scale <= pwdata[3:0];
        REG_OUTPUT_MODE: cfg.output_mode <= pwdata[0];
        REG_RED_FIELD: begin
          cfg.red_field <= pwdata;
          cfg.red_shift <= low_bit_pos(pwdata);
        end
        REG_GREEN_FIELD: begin
          cfg.green_field <= pwdata;
          cfg.green_shift <= low_bit_pos(pwdata);
        end
        REG_BLUE_FIELD: begin
          cfg.blue_field <= pwdata;
          cfg.blue_shift <= low_bit_pos(pwdata);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_SCALE: prdata = {28'd0, cfg.scale};
      REG_OUTPUT_MODE: prdata = {31'd0, cfg.output_mode};
      REG_RED_FIELD: prdata = cfg.red_field;
      REG_GREEN_FIELD: prdata = cfg.green_field;
      REG_BLUE_FIELD: prdata = cfg.blue_field;
      default: prdata = 32'd0;
    endcase
  end

endmodule

// ----- hdl/pep_lookup.sv -----
// Palette store and lookup stage: writes the palette, reads it for each pixel.
module pep_lookup (
  input  logic           clk,
  input  logic           rst,
  input  pep_pkg::cfg_t  cfg,
  input  logic           item_valid,
  output logic           item_ready,
  input  pep_pkg::item_t item,
  output logic           job_valid,
  input  logic           job_ready,
  output pep_pkg::job_t  job
);
  import pep_pkg::*;

  logic              a_valid;
  logic [7:0]        a_idx;
  logic              a_eol;
  logic              a_inrange;
  logic              accept;
  logic              in_range;
  logic              we;
  logic              re;
  logic [23:0]       rdata;
  logic [23:0]       entry;

  assign item_ready = !a_valid || job_ready;
  assign accept = item_valid && item_ready;
  assign in_range = {1'b0, item.index} < 9'(PALETTE_ENTRIES);
  assign we = accept && (item.mode == MODE_PAL_WRITE) && in_range;
  assign re = accept && (item.mode == MODE_PIXEL);

  pep_ram #(
    .WIDTH(24),
    .DEPTH(PALETTE_ENTRIES)
  ) u_palette (
    .clk  (clk),
    .we   (we),
    .waddr(item.index[PAL_AW-1:0]),
    .wdata({item.red, item.green, item.blue}),
    .re   (re),
    .raddr(item.index[PAL_AW-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (re) begin
      a_valid <= 1'b1;
    end else if (job_ready) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      a_idx <= item.index;
      a_eol <= item.last_in_line;
      a_inrange <= in_range;
    end
  end

  // rdata holds until the next pixel read, which only happens as this one leaves
  assign entry = a_inrange ? rdata : 24'd0;
  assign job_valid = a_valid;
  assign job.index = a_idx;
  assign job.eol = a_eol;
  assign job.word = place(entry[23:16], cfg.red_field, cfg.red_shift)
                  | place(entry[15:8], cfg.green_field, cfg.green_shift)
                  | place(entry[7:0], cfg.blue_field, cfg.blue_shift);

endmodule

// ----- hdl/pep_pack.sv -----
// Replication and byte packing stage with the output register.
module pep_pack (
  input  logic          clk,
  input  logic          rst,
  input  pep_pkg::cfg_t cfg,
  input  logic          job_valid,
  output logic          job_ready,
  input  pep_pkg::job_t job,
  output logic          res_valid,
  input  logic          res_ready,
  output pep_pkg::res_t res
);
  import pep_pkg::*;

  logic        b_valid;
  logic [31:0] b_word;
  logic [7:0]  b_idx;
  logic        b_eol;
  logic [3:0]  cnt;
  logic [31:0] acc;
  logic [1:0]  off;

  logic        out_free;
  logic        step;
  logic        done;
  logic        emit;
  logic [31:0] w;
  logic        wlast;
  logic [3:0]  r;
  logic [2:0]  room;
  logic [3:0]  k4;
  logic [2:0]  k;
  logic        full;
  logic [2:0]  hi;
  logic [31:0] newacc;
  logic [31:0] acc_next;
  logic [1:0]  off_next;

  assign out_free = !res_valid || res_ready;
  assign step = b_valid && out_free;
  assign done = step && (r == 4'd0);
  assign job_ready = !b_valid || done;

  always_comb begin
    room = 3'd4 - {1'b0, off};
    full = cnt >= {1'b0, room};
    k4 = full ? {1'b0, room} : cnt;
    k = k4[2:0];
    hi = {1'b0, off} + k;
    newacc = acc;
    for (int j = 0; j < 4; j++) begin
      if (3'(j) >= {1'b0, off} && 3'(j) < hi) newacc[8*j +: 8] = b_idx;
    end
    acc_next = acc;
    off_next = off;
    if (cfg.output_mode == OUT_TRUE_COLOR) begin
      r = cnt - 4'd1;
      emit = 1'b1;
      w = b_word;
      wlast = r == 4'd0;
      if (r == 4'd0 && b_eol) begin
        acc_next = 32'd0;
        off_next = 2'd0;
      end
    end else begin
      r = cnt - k4;
      w = newacc;
      // after a full word the offset is zero: more words follow only for
      // another full word or a line-end flush
      wlast = (r == 4'd0) || (r < 4'd4 && !b_eol);
      if (full) begin
        emit = 1'b1;
        acc_next = 32'd0;
        off_next = 2'd0;
      end else if (b_eol) begin
        emit = 1'b1;
        acc_next = 32'd0;
        off_next = 2'd0;
      end else begin
        emit = 1'b0;
        acc_next = newacc;
        off_next = hi[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      res_valid <= 1'b0;
      acc <= 32'd0;
      off <= 2'd0;
    end else begin
      if (job_valid && job_ready) begin
        b_valid <= 1'b1;
      end else if (done) begin
        b_valid <= 1'b0;
      end
      if (step && emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (step) begin
        acc <= acc_next;
        off <= off_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      b_word <= job.word;
      b_idx <= job.index;
      b_eol <= job.eol;
      cnt <= eff_scale(cfg.scale);
    end else if (step) begin
      cnt <= r;
    end
    if (step && emit) begin
      res.word <= w;
      res.last <= wlast;
      res.line_end <= wlast && b_eol;
    end
  end

endmodule

// ----- hdl/palette_expand_pixel_replicate.sv -----
// Top level of the palette expander with horizontal pixel replication.
// Items enter on the item channel; a palette write gives no word. A pixel has
// its palette entry read from a 256x24 RAM with a registered read in the lookup
// stage, then sits in the packer, which gives at most one word per cycle into
// the output register while that register is free. In true-color mode a pixel
// gives scale copies of its mapped word, with scale clamped to 1 to 8; in packed
// mode scale copies of its index byte fill words of up to four bytes, and a word
// is given when it fills or at line end. The next pixel is looked up while the
// current one is packed, so the packer and the output port set the rate. The
// palette has no reset; entries must be written before they are looked up.
module palette_expand_pixel_replicate (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  pep_pkg::item_t              item,
  output logic                        res_valid,
  input  logic                        res_ready,
  output pep_pkg::res_t               res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pep_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import pep_pkg::*;

  cfg_t cfg;
  logic job_valid;
  logic job_ready;
  job_t job;

  pep_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  pep_lookup u_lookup (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item      (item),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  pep_pack u_pack (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .job_valid(job_valid),
    .job_ready(job_ready),
    .job      (job),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Testbench for the palette expander: directed and random items checked word by word.
module tb;
  import pep_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 30;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 48;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_ready;
  item_t              item = '0;
  logic               res_valid;
  logic               res_ready = 1'b0;
  res_t               res;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  palette_expand_pixel_replicate uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // stimulus and expected words
  item_t       item_backlog[$];
  res_t        pending_words[$];

  // predictor copy of the block state and registers
  logic [23:0] pal_model [PALETTE_ENTRIES];
  logic [31:0] acc_model = '0;
  logic [1:0]  offs_model = '0;
  logic [3:0]  scale_r = 4'd1;
  logic        omode_r = OUT_PACKED;
  logic [31:0] rmask_r = 32'h00FF0000;
  logic [31:0] gmask_r = 32'h0000FF00;
  logic [31:0] bmask_r = 32'h000000FF;

  // palette entries that have a write queued, so lookups stay defined
  bit          seeded [PALETTE_ENTRIES];

  int          items_queued = 0;
  int          items_taken = 0;
  int          words_seen = 0;
  int          err_cnt = 0;
  logic        item_fire = 1'b0;
  logic        res_fire = 1'b0;
  bit          idle_on = 1'b1;
  int          hold_req = 0;

  function automatic logic [31:0] fit_component(logic [7:0] c, logic [31:0] m);
    int sh;
    sh = 0;
    while (sh < 31 && m != 32'd0 && !m[sh]) sh++;
    return ({24'd0, c} << sh) & m;
  endfunction

  function automatic int repeat_count(logic [3:0] s);
    if (s == 4'd0) return 1;
    if (s > MAX_SCALE) return MAX_SCALE;
    return int'(s);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    err_cnt++;
    if (err_cnt <= 40) $display("tb: mismatch on %s: got %h, want %h", what, got, want);
  endtask

  task automatic expand_item(item_t it);
    res_t        outw[$];
    res_t        w;
    logic [23:0] e;
    int          reps;
    reps = repeat_count(scale_r);
    w = '0;
    if (it.mode == MODE_PAL_WRITE) begin
      pal_model[it.index] = {it.red, it.green, it.blue};
    end else begin
      if (omode_r == OUT_PACKED) begin
        for (int i = 0; i < reps; i++) begin
          acc_model |= 32'(it.index) << (8 * offs_model);
          offs_model++;
          if (offs_model == 2'd0) begin
            w.word = acc_model;
            outw.push_back(w);
            acc_model = '0;
          end
        end
        // flush the partial word at line end
        if (it.last_in_line && offs_model != 2'd0) begin
          w.word = acc_model;
          outw.push_back(w);
          acc_model = '0;
          offs_model = '0;
        end
      end else begin
        e = pal_model[it.index];
        w.word = fit_component(e[23:16], rmask_r) | fit_component(e[15:8], gmask_r)
               | fit_component(e[7:0], bmask_r);
        for (int i = 0; i < reps; i++) outw.push_back(w);
        // true color only touches the packing state at line end
        if (it.last_in_line) begin
          acc_model = '0;
          offs_model = '0;
        end
      end
      if (outw.size() > 0) begin
        w = outw[outw.size() - 1];
        w.last = 1'b1;
        w.line_end = it.last_in_line;
        outw[outw.size() - 1] = w;
      end
      foreach (outw[k]) pending_words.push_back(outw[k]);
    end
  endtask

  task automatic check_word(res_t got);
    res_t want;
    words_seen++;
    if (pending_words.size() == 0) begin
      report_mismatch("word with none expected", got.word, 32'd0);
    end else begin
      want = pending_words.pop_front();
      if (got.word !== want.word) report_mismatch("word", got.word, want.word);
      if (got.last !== want.last) report_mismatch("last", 32'(got.last), 32'(want.last));
      if (got.line_end !== want.line_end)
        report_mismatch("line_end", 32'(got.line_end), 32'(want.line_end));
    end
  endtask

  // sample both handshakes, check the output word, then predict the input item
  always @(posedge clk) begin
    item_fire <= !rst && item_valid && item_ready;
    res_fire <= !rst && res_valid && res_ready;
    if (!rst && res_valid && res_ready) check_word(res);
    if (!rst && item_valid && item_ready) begin
      items_taken++;
      expand_item(item);
    end
  end

  // item driver
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        item_valid <= 1'b0;
      end else if (item_backlog.size() > 0) begin
        item <= item_backlog.pop_front();
        item_valid <= 1'b1;
        gap_left = idle_on ? $urandom_range(0, 10) : 0;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // word receiver, with an optional long hold-off
  int stall_left = 0;
  int hold_left = 0;
  int hold_done = 0;
  always @(negedge clk) begin
    if (hold_req != hold_done) begin
      hold_done = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (rst) begin
      res_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_ready <= 1'b0;
    end else begin
      if (res_fire) stall_left = idle_on ? $urandom_range(0, 10) : 0;
      if (stall_left > 0) begin
        stall_left--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(negedge clk);
      if (item_fire || res_fire) quiet = 0;
      else quiet++;
    end
    $display("tb: done, errors");
    $finish;
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    case (idx)
      REG_SCALE:       scale_r = val[3:0];
      REG_OUTPUT_MODE: omode_r = val[0];
      REG_RED_FIELD:   rmask_r = val;
      REG_GREEN_FIELD: gmask_r = val;
      REG_BLUE_FIELD:  bmask_r = val;
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic push_pal(logic [7:0] idx, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                          logic eol);
    item_t it;
    it.mode = MODE_PAL_WRITE;
    it.index = idx;
    it.red = r;
    it.green = g;
    it.blue = b;
    it.last_in_line = eol;
    seeded[idx] = 1'b1;
    item_backlog.push_back(it);
    items_queued++;
  endtask

  task automatic push_pix(logic [7:0] idx, logic eol);
    item_t it;
    it.mode = MODE_PIXEL;
    it.index = idx;
    // color fields are don't-care on pixels
    it.red = 8'($urandom);
    it.green = 8'($urandom);
    it.blue = 8'($urandom);
    it.last_in_line = eol;
    item_backlog.push_back(it);
    items_queued++;
  endtask

  function automatic logic [7:0] pick_index(bit lookup);
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    while (lookup && !seeded[v]) v = 8'($urandom_range(0, 255));
    return v;
  endfunction

  function automatic logic [31:0] rand_mask();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h1 << $urandom_range(0, 31);
      3: return 32'hFF << $urandom_range(0, 24);
      4: return 32'h3F << $urandom_range(0, 26);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [3:0] rand_scale();
    case ($urandom_range(0, 9))
      0: return 4'd0;
      1: return 4'($urandom_range(9, 15));
      default: return 4'($urandom_range(1, 8));
    endcase
  endfunction

  // wait for every queued item to be taken and every word to arrive
  task automatic settle();
    do @(negedge clk);
    while (items_taken != items_queued || pending_words.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic random_phase(int p);
    int         made;
    int         len;
    logic [7:0] v;
    bit         tc;
    reg_write(REG_SCALE, p == 0 ? 32'd8 : (p == 1 ? 32'd1 : 32'(rand_scale())));
    reg_write(REG_OUTPUT_MODE, 32'(p < 2 ? p : $urandom_range(0, 1)));
    reg_write(REG_RED_FIELD, rand_mask());
    reg_write(REG_GREEN_FIELD, rand_mask());
    reg_write(REG_BLUE_FIELD, rand_mask());
    tc = (omode_r == OUT_TRUE_COLOR);
    @(posedge clk);
    idle_on = (p % 3 != 2);
    made = 0;
    while (made < PHASE_ITEMS) begin
      case ($urandom_range(0, 9))
        0: begin
          push_pal(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
          made++;
        end
        1: begin
          // stray pixel, line left open
          push_pix(pick_index(tc), 1'b0);
          made++;
        end
        2: begin
          // write then look up the same entry right away
          v = 8'($urandom);
          push_pal(v, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
          push_pix(v, 1'b1);
          made += 2;
        end
        default: begin
          len = $urandom_range(1, 10);
          for (int k = 0; k < len; k++) push_pix(pick_index(tc), k == len - 1);
          made += len;
        end
      endcase
    end
    // stall the output so the block backs up onto its input
    if (p == 3) hold_req++;
    settle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: packed, scale 1
    push_pal(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
    push_pal(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    push_pal(8'h12, 8'hA5, 8'h5A, 8'h3C, 1'b1);
    push_pix(8'h00, 1'b0);
    push_pix(8'hFF, 1'b0);
    push_pix(8'h5A, 1'b0);
    push_pix(8'hA5, 1'b1);
    push_pix(8'hFF, 1'b0);
    push_pix(8'h01, 1'b1);
    push_pix(8'h80, 1'b1);
    settle();

    // true color, scale above the limit saturates
    reg_write(REG_SCALE, 32'd15);
    reg_write(REG_OUTPUT_MODE, 32'(OUT_TRUE_COLOR));
    reg_write(REG_RED_FIELD, 32'h00FF0000);
    reg_write(REG_GREEN_FIELD, 32'h0000FF00);
    reg_write(REG_BLUE_FIELD, 32'h000000FF);
    @(posedge clk);
    push_pix(8'hFF, 1'b0);
    push_pix(8'h12, 1'b1);
    settle();

    // mask extremes, scale 0 acts as 1
    reg_write(REG_SCALE, 32'd0);
    reg_write(REG_RED_FIELD, 32'hFFFF_FFFF);
    reg_write(REG_GREEN_FIELD, 32'd0);
    reg_write(REG_BLUE_FIELD, 32'h8000_0000);
    @(posedge clk);
    push_pix(8'h12, 1'b0);
    push_pix(8'hFF, 1'b1);
    settle();

    // mode changes in the middle of a line
    reg_write(REG_SCALE, 32'd5);
    reg_write(REG_OUTPUT_MODE, 32'(OUT_PACKED));
    @(posedge clk);
    push_pix(8'h11, 1'b0);
    settle();
    reg_write(REG_OUTPUT_MODE, 32'(OUT_TRUE_COLOR));
    @(posedge clk);
    push_pix(8'h12, 1'b0);
    settle();
    reg_write(REG_OUTPUT_MODE, 32'(OUT_PACKED));
    @(posedge clk);
    push_pix(8'h22, 1'b1);
    settle();
    reg_write(REG_SCALE, 32'd1);
    @(posedge clk);
    push_pix(8'h33, 1'b0);
    settle();
    // true-color line end drops the partial packed word
    reg_write(REG_OUTPUT_MODE, 32'(OUT_TRUE_COLOR));
    @(posedge clk);
    push_pix(8'h00, 1'b1);
    settle();
    reg_write(REG_OUTPUT_MODE, 32'(OUT_PACKED));
    @(posedge clk);
    push_pix(8'h44, 1'b1);
    settle();

    for (int p = 0; p < RAND_PHASES; p++) random_phase(p);

    $display("tb: %0d items over %0d random phases, %0d words checked, %0d mismatches",
             items_taken, RAND_PHASES, words_seen, err_cnt);
    $display("tb: covered packed and true-color lines, scale clamping, mask edges, %s",
             "mode switches mid-line and a long output stall");
    if (err_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
